// ===== src/sobel_edge_threshold_assert.svh =====
// Assertion macros used by the edge detector top module.
// Define NO_ASSERTIONS to compile every use down to nothing.
`ifndef SOBEL_EDGE_THRESHOLD_ASSERT_SVH
`define SOBEL_EDGE_THRESHOLD_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Checked at every clock edge, reset included.
`define SET_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
// Checked only while reset is released.
`define SET_ASSERT_RST(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`else
`define SET_ASSERT_ALWAYS(lbl, clk, prop, msg)
`define SET_ASSERT_RST(lbl, clk, rst_n, prop, msg)
`endif
`endif

// ===== src/set_pkg.sv =====
package set_pkg;

  localparam int PIX_W      = 8;
  localparam int ROW_W      = 12;
  localparam int COL_W      = 10;
  localparam int THR_W      = 11;
  localparam int FW_W       = 11;
  localparam int FH_W       = 13;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;
  localparam int GRAD_W     = 12;
  localparam int SUM_W      = 10;
  localparam int SQ_W       = 22;
  localparam int WIN_N      = 3;
  localparam int MIN_DIM    = 3;

  localparam logic [THR_W-1:0] THR_RESET    = 11'd128;
  localparam logic [FW_W-1:0]  WIDTH_RESET  = 11'd640;
  localparam logic [FH_W-1:0]  HEIGHT_RESET = 13'd480;
  localparam logic [FH_W-1:0]  MAX_HEIGHT   = 13'd4096;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_THRESHOLD = 2'd0,
    CFG_WIDTH     = 2'd1,
    CFG_HEIGHT    = 2'd2
  } cfg_idx_t;

  typedef logic [PIX_W-1:0] pix_t;

  // One window column, top row first.
  typedef struct packed {
    pix_t top;
    pix_t mid;
    pix_t bot;
  } col_t;

  // Position information that travels with a pixel through the pipeline.
  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic             frame_done;
  } meta_t;

  typedef struct packed {
    logic [ROW_W-1:0] center_row;
    logic [COL_W-1:0] center_col;
    logic             horiz_edge;
    logic             vert_edge;
    logic             mag_edge;
    pix_t             center_gray;
    logic             frame_done;
  } res_t;

endpackage

// ===== src/set_line_buf.sv =====
module set_line_buf #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic                clk,
  input  logic                rd_en,
  input  logic [AW-1:0]       rd_addr,
  output set_pkg::pix_t       rd_upper,
  output set_pkg::pix_t       rd_middle,
  input  logic                wr_en,
  input  logic [AW-1:0]       wr_addr,
  input  set_pkg::pix_t       wr_upper,
  input  set_pkg::pix_t       wr_middle
);

  set_pkg::pix_t upper_mem [DEPTH];
  set_pkg::pix_t middle_mem [DEPTH];
  set_pkg::pix_t rd_upper_r;
  set_pkg::pix_t rd_middle_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      upper_mem[wr_addr]  <= wr_upper;
      middle_mem[wr_addr] <= wr_middle;
    end
  end

  // Read data holds while the pipeline is stalled.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_upper_r  <= upper_mem[rd_addr];
      rd_middle_r <= middle_mem[rd_addr];
    end
  end

  assign rd_upper  = rd_upper_r;
  assign rd_middle = rd_middle_r;

endmodule

// ===== src/set_win_cell.sv =====
module set_win_cell (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          shift_en,
  input  set_pkg::col_t col_in,
  output set_pkg::col_t col_out
);

  set_pkg::col_t col_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
    end else if (shift_en) begin
      col_r <= col_in;
    end
  end

  assign col_out = col_r;

endmodule

// ===== src/set_grad.sv =====
module set_grad (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         en,
  input  logic                         in_v,
  input  set_pkg::col_t                left,
  input  set_pkg::col_t                center,
  input  set_pkg::col_t                right,
  input  set_pkg::meta_t               meta,
  input  logic [set_pkg::THR_W-1:0]    thr,
  output logic                         out_v,
  output set_pkg::res_t                res
);

  localparam int GW = set_pkg::GRAD_W;
  localparam int SW = set_pkg::SUM_W;
  localparam int QW = set_pkg::SQ_W;

  logic [SW-1:0] sum_r, sum_l, sum_b, sum_t;
  logic signed [GW-1:0] gx, gy, thr_s;
  logic signed [2*GW-1:0] sqx_full, sqy_full;
  logic [2*set_pkg::THR_W-1:0] t2_full;
  logic [QW-1:0] mag2;

  logic                 a_v_r;
  logic signed [GW-1:0] a_gx_r, a_gy_r;
  set_pkg::meta_t       a_meta_r;
  set_pkg::pix_t        a_gray_r;

  logic                 b_v_r;
  logic [QW-1:0]        b_sqx_r, b_sqy_r, b_t2_r;
  logic                 b_horiz_r, b_vert_r;
  set_pkg::meta_t       b_meta_r;
  set_pkg::pix_t        b_gray_r;

  // Weighted 1-2-1 sums of the four window edges.
  always_comb begin
    sum_r = SW'(right.top) + {1'b0, right.mid, 1'b0} + SW'(right.bot);
    sum_l = SW'(left.top) + {1'b0, left.mid, 1'b0} + SW'(left.bot);
    sum_b = SW'(left.bot) + {1'b0, center.bot, 1'b0} + SW'(right.bot);
    sum_t = SW'(left.top) + {1'b0, center.top, 1'b0} + SW'(right.top);
    gx    = $signed({2'b00, sum_r}) - $signed({2'b00, sum_l});
    gy    = $signed({2'b00, sum_b}) - $signed({2'b00, sum_t});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
    end else if (en) begin
      a_v_r <= in_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_gx_r   <= gx;
      a_gy_r   <= gy;
      a_meta_r <= meta;
      a_gray_r <= center.mid;
    end
  end

  always_comb begin
    thr_s    = $signed({1'b0, thr});
    sqx_full = a_gx_r * a_gx_r;
    sqy_full = a_gy_r * a_gy_r;
    t2_full  = thr * thr;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_v_r <= 1'b0;
    end else if (en) begin
      b_v_r <= a_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b_sqx_r   <= sqx_full[QW-1:0];
      b_sqy_r   <= sqy_full[QW-1:0];
      b_t2_r    <= t2_full[QW-1:0];
      b_horiz_r <= (a_gx_r >= thr_s);
      b_vert_r  <= (a_gy_r >= thr_s);
      b_meta_r  <= a_meta_r;
      b_gray_r  <= a_gray_r;
    end
  end

  assign mag2 = b_sqx_r + b_sqy_r;

  always_comb begin
    res.center_row  = b_meta_r.row;
    res.center_col  = b_meta_r.col;
    res.horiz_edge  = b_horiz_r;
    res.vert_edge   = b_vert_r;
    res.mag_edge    = (mag2 >= b_t2_r);
    res.center_gray = b_gray_r;
    res.frame_done  = b_meta_r.frame_done;
  end

  assign out_v = b_v_r;

endmodule

// ===== src/sobel_edge_threshold.sv =====
// 3x3 Sobel edge detector with threshold tests.
// Pixels arrive one word per cycle on the in_ channel (valid/ready), in raster
// order. Every interior pixel of the frame yields one word on the out_ channel
// with the window center position, edge bits for horizontal gradient,
// vertical gradient and exact gradient magnitude, each against the threshold,
// the center gray value and a flag on the last interior pixel of the frame.
// Border pixels are consumed and yield no word.
// Throughput is one pixel per cycle while the skid stage is empty. The result
// word of a pixel that completes its window passes the line store read stage,
// the window shift, the two arithmetic stages and the output register.
// The output register is backed by a one-word skid stage, so in_ready only
// drops when the receiver has stalled long enough to fill both; it is then
// taken from a register and comes back the cycle after the skid word drains.
// Synchronous reset clears the position counters, the window and all valid
// flags, and loads the threshold, width and height with their defaults. The
// line stores are not cleared; the first two rows of a frame refill them
// before any result depends on their contents. Configuration words on the
// cfg_ channel are always accepted and should only be sent while no pixel is
// in flight.
`include "sobel_edge_threshold_assert.svh"

module sobel_edge_threshold #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [set_pkg::PIX_W-1:0]        in_gray_pixel,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [set_pkg::ROW_W-1:0]        out_center_row,
  output logic [set_pkg::COL_W-1:0]        out_center_col,
  output logic                             out_horiz_edge,
  output logic                             out_vert_edge,
  output logic                             out_mag_edge,
  output logic [set_pkg::PIX_W-1:0]        out_center_gray,
  output logic                             out_frame_done,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [set_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [set_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int AW = $clog2(MAX_WIDTH);
  localparam int EW = ((AW > set_pkg::FW_W) ? AW : set_pkg::FW_W) + 1;
  localparam int FH = set_pkg::FH_W;

  // Configuration registers.
  logic [set_pkg::THR_W-1:0] thr_r;
  logic [set_pkg::FW_W-1:0]  fw_r;
  logic [FH-1:0]             fh_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= set_pkg::THR_RESET;
      fw_r  <= set_pkg::WIDTH_RESET;
      fh_r  <= set_pkg::HEIGHT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (set_pkg::cfg_idx_t'(cfg_index))
        set_pkg::CFG_THRESHOLD: thr_r <= cfg_data[set_pkg::THR_W-1:0];
        set_pkg::CFG_WIDTH:     fw_r  <= cfg_data[set_pkg::FW_W-1:0];
        set_pkg::CFG_HEIGHT:    fh_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // The whole pipeline moves together; it only freezes while the skid
  // stage holds a word.
  logic pipe_en;
  logic in_fire;
  logic skid_v_r;

  assign pipe_en  = !skid_v_r;
  assign in_ready = !skid_v_r;
  assign in_fire  = in_valid && in_ready;

  // Effective frame size: MIN_DIM up to the line store width and MAX_HEIGHT.
  logic [EW-1:0] fw_ext, w_eff, col_inc;
  logic [FH-1:0] h_eff, row_inc;
  logic          row_end, frame_end;
  logic [AW-1:0] col_r;
  logic [set_pkg::ROW_W-1:0] row_r;

  always_comb begin
    fw_ext = EW'(fw_r);
    if (fw_ext < EW'(set_pkg::MIN_DIM)) begin
      w_eff = EW'(set_pkg::MIN_DIM);
    end else if (fw_ext > EW'(MAX_WIDTH)) begin
      w_eff = EW'(MAX_WIDTH);
    end else begin
      w_eff = fw_ext;
    end
    if (fh_r < FH'(set_pkg::MIN_DIM)) begin
      h_eff = FH'(set_pkg::MIN_DIM);
    end else if (fh_r > set_pkg::MAX_HEIGHT) begin
      h_eff = set_pkg::MAX_HEIGHT;
    end else begin
      h_eff = fh_r;
    end
    col_inc   = EW'(col_r) + EW'(1);
    row_inc   = FH'(row_r) + FH'(1);
    row_end   = (col_inc >= w_eff);
    frame_end = row_end && (row_inc >= h_eff);
  end

  // Position of the next incoming pixel.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (in_fire) begin
      if (row_end) begin
        col_r <= '0;
        row_r <= frame_end ? '0 : row_inc[set_pkg::ROW_W-1:0];
      end else begin
        col_r <= col_r + AW'(1);
      end
    end
  end

  // Result metadata, formed when the pixel is accepted.
  logic [AW-1:0]                 col_m1;
  logic [AW+set_pkg::COL_W-1:0]  col_m1_ext;
  logic                          emit;
  set_pkg::meta_t                meta_in;

  always_comb begin
    col_m1             = col_r - AW'(1);
    col_m1_ext         = (AW + set_pkg::COL_W)'(col_m1);
    emit               = (row_r >= set_pkg::ROW_W'(2)) && (col_r >= AW'(2));
    meta_in.row        = row_r - set_pkg::ROW_W'(1);
    meta_in.col        = col_m1_ext[set_pkg::COL_W-1:0];
    meta_in.frame_done = frame_end;
  end

  // Stage 1: line store read in flight alongside the pixel.
  logic           s1_v_r;
  logic           s1_emit_r;
  logic [AW-1:0]  s1_addr_r;
  set_pkg::pix_t  s1_px_r;
  set_pkg::meta_t s1_meta_r;
  set_pkg::pix_t  rd_upper, rd_middle;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (pipe_en) begin
      s1_v_r <= in_fire;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      s1_emit_r <= emit;
      s1_addr_r <= col_r;
      s1_px_r   <= in_gray_pixel;
      s1_meta_r <= meta_in;
    end
  end

  // Each column moves up one row in the stores as the new pixel goes in.
  set_line_buf #(
    .DEPTH (MAX_WIDTH),
    .AW    (AW)
  ) u_line_buf (
    .clk       (clk),
    .rd_en     (pipe_en),
    .rd_addr   (col_r),
    .rd_upper  (rd_upper),
    .rd_middle (rd_middle),
    .wr_en     (pipe_en && s1_v_r),
    .wr_addr   (s1_addr_r),
    .wr_upper  (rd_middle),
    .wr_middle (s1_px_r)
  );

  // Stage 2: the window, a chain of three column cells. The newest column
  // enters on the right and every column steps left once per pixel.
  set_pkg::col_t new_col;
  set_pkg::col_t win_in  [set_pkg::WIN_N];
  set_pkg::col_t win_col [set_pkg::WIN_N];
  logic          win_shift;

  assign win_shift   = pipe_en && s1_v_r;
  assign new_col.top = rd_upper;
  assign new_col.mid = rd_middle;
  assign new_col.bot = s1_px_r;
  assign win_in[2]   = new_col;
  assign win_in[1]   = win_col[2];
  assign win_in[0]   = win_col[1];

  for (genvar k = 0; k < set_pkg::WIN_N; k++) begin : g_cell
    set_win_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .shift_en (win_shift),
      .col_in   (win_in[k]),
      .col_out  (win_col[k])
    );
  end

  logic           s2_v_r;
  set_pkg::meta_t s2_meta_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (pipe_en) begin
      s2_v_r <= s1_v_r && s1_emit_r;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      s2_meta_r <= s1_meta_r;
    end
  end

  // Stages 3 and 4: gradients, squares and threshold tests.
  logic          g_v;
  set_pkg::res_t g_res;

  set_grad u_grad (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (pipe_en),
    .in_v   (s2_v_r),
    .left   (win_col[0]),
    .center (win_col[1]),
    .right  (win_col[2]),
    .meta   (s2_meta_r),
    .thr    (thr_r),
    .out_v  (g_v),
    .res    (g_res)
  );

  // Output register with a one-word skid stage behind it.
  logic          push;
  logic          out_v_r, out_v_nxt, skid_v_nxt;
  set_pkg::res_t out_res_r, out_res_nxt, skid_res_r, skid_res_nxt;

  assign push = pipe_en && g_v;

  always_comb begin
    out_v_nxt    = out_v_r;
    out_res_nxt  = out_res_r;
    skid_v_nxt   = skid_v_r;
    skid_res_nxt = skid_res_r;
    if (!out_v_r || out_ready) begin
      if (skid_v_r) begin
        out_v_nxt   = 1'b1;
        out_res_nxt = skid_res_r;
        skid_v_nxt  = 1'b0;
      end else begin
        out_v_nxt   = push;
        out_res_nxt = g_res;
      end
    end else if (push) begin
      skid_v_nxt   = 1'b1;
      skid_res_nxt = g_res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      out_v_r  <= out_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_res_r  <= out_res_nxt;
    skid_res_r <= skid_res_nxt;
  end

  assign out_valid       = out_v_r;
  assign out_center_row  = out_res_r.center_row;
  assign out_center_col  = out_res_r.center_col;
  assign out_horiz_edge  = out_res_r.horiz_edge;
  assign out_vert_edge   = out_res_r.vert_edge;
  assign out_mag_edge    = out_res_r.mag_edge;
  assign out_center_gray = out_res_r.center_gray;
  assign out_frame_done  = out_res_r.frame_done;

  // The skid stage only ever holds a word behind a waiting output word.
  `SET_ASSERT_RST(a_skid_behind_out, clk, rst_n, skid_v_r |-> out_v_r,
    "skid word without output word")
  // The last pixel of a frame returns the position counters to the origin.
  `SET_ASSERT_RST(a_frame_wrap, clk, rst_n,
    (in_fire && frame_end) |=> (col_r == '0 && row_r == '0),
    "counters did not wrap at frame end")
  // The column counter always addresses a line store entry.
  `SET_ASSERT_RST(a_col_bound, clk, rst_n, (AW+1)'(col_r) < (AW+1)'(MAX_WIDTH),
    "column counter beyond line store")
  // A frozen pipeline leaves the window untouched.
  `SET_ASSERT_RST(a_stall_window, clk, rst_n,
    !pipe_en |=> $stable(win_col[0]) && $stable(win_col[2]),
    "window moved during stall")
  // Reset empties the output register.
  `SET_ASSERT_ALWAYS(a_reset_out, clk, !rst_n |=> !out_v_r, "output valid after reset")

endmodule
